/* rtl/mtwg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mersenne twister word generator package
// Shared widths, codes, constants and stage types of the generator.
// ----------------------------------------------------------------------------
package mtwg_pkg;

   localparam int WORD_WIDTH  = 32;
   localparam int INDEX_WIDTH = 10;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_DRAW = 1'b1;

   localparam logic [WORD_WIDTH-1:0] HIGH_BIT = 32'h8000_0000;
   localparam logic [WORD_WIDTH-1:0] LOW_BITS = 32'h7FFF_FFFF;
   localparam logic [WORD_WIDTH-1:0] FEEDBACK = 32'h9908_B0DF;

   localparam int OUT_DEPTH   = 3;
   localparam int LEVEL_WIDTH = 2;
   localparam int PTR_WIDTH   = 2;

   typedef struct packed {
      logic                   valid;
      logic                   draw;
      logic                   raw;
      logic                   load_en;
      logic [INDEX_WIDTH-1:0] waddr;
      logic [WORD_WIDTH-1:0]  load_value;
   } stage_type;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0] a;
      logic [INDEX_WIDTH-1:0] b;
      logic [INDEX_WIDTH-1:0] h;
   } read_type;

   typedef struct packed {
      logic                   en;
      logic [INDEX_WIDTH-1:0] addr;
      logic [WORD_WIDTH-1:0]  data;
   } write_type;

endpackage

/* rtl/mtwg_channels.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mersenne twister word generator channels
// Valid/ready interfaces for the request and the response channel.
// ----------------------------------------------------------------------------
interface mtwg_req_if
   import mtwg_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic                   operation;
   logic [INDEX_WIDTH-1:0] word_index;
   logic [WORD_WIDTH-1:0]  word_value;

   modport source (output valid, output operation, output word_index, output word_value,
                   input ready);
   modport sink   (input valid, input operation, input word_index, input word_value,
                   output ready);
endinterface

interface mtwg_rsp_if
   import mtwg_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [WORD_WIDTH-1:0] random_word;

   modport source (output valid, output random_word, input ready);
   modport sink   (input valid, input random_word, output ready);
endinterface

/* rtl/mtwg_state_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mersenne twister state store
// State word memory with two read ports and a top bit memory with one read
// port, sharing one write port. Reads are registered and write-first.
// ----------------------------------------------------------------------------
module mtwg_state_store
   import mtwg_pkg::*;
#(
   parameter int STATE_LENGTH = 624
) (
   input  logic                  clock,
   input  read_type              rd,
   input  write_type             wr,
   output logic [WORD_WIDTH-1:0] rd_a_word,
   output logic [WORD_WIDTH-1:0] rd_b_word,
   output logic                  rd_h_bit
);

   localparam int AW = $clog2(STATE_LENGTH);

   logic [WORD_WIDTH-1:0] word_mem [STATE_LENGTH];
   logic                  top_mem  [STATE_LENGTH];

   logic [WORD_WIDTH-1:0] rd_a_ff;
   logic [WORD_WIDTH-1:0] rd_b_ff;
   logic                  rd_h_ff;

   logic [AW-1:0] waddr;
   logic [AW-1:0] raddr_a;
   logic [AW-1:0] raddr_b;
   logic [AW-1:0] raddr_h;

   assign waddr   = wr.addr[AW-1:0];
   assign raddr_a = rd.a[AW-1:0];
   assign raddr_b = rd.b[AW-1:0];
   assign raddr_h = rd.h[AW-1:0];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         word_mem[waddr] <= wr.data;
         top_mem[waddr]  <= wr.data[WORD_WIDTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && (waddr == raddr_a)) begin
         rd_a_ff <= wr.data;
      end else begin
         rd_a_ff <= word_mem[raddr_a];
      end
      if (wr.en && (waddr == raddr_b)) begin
         rd_b_ff <= wr.data;
      end else begin
         rd_b_ff <= word_mem[raddr_b];
      end
      if (wr.en && (waddr == raddr_h)) begin
         rd_h_ff <= wr.data[WORD_WIDTH-1];
      end else begin
         rd_h_ff <= top_mem[raddr_h];
      end
   end

   assign rd_a_word = rd_a_ff;
   assign rd_b_word = rd_b_ff;
   assign rd_h_bit  = rd_h_ff;

endmodule

/* rtl/mtwg_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mersenne twister sequencer
// Keeps the read position and the raw pass flag, issues the memory reads of
// an accepted item and registers its control for the mixing stage.
// ----------------------------------------------------------------------------
module mtwg_sequencer
   import mtwg_pkg::*;
#(
   parameter int STATE_LENGTH = 624,
   parameter int MIX_OFFSET   = 397
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   operation,
   input  logic [INDEX_WIDTH-1:0] word_index,
   input  logic [WORD_WIDTH-1:0]  word_value,
   output read_type               rd,
   output stage_type              stage
);

   localparam int AW   = $clog2(STATE_LENGTH);
   localparam int MOFF = MIX_OFFSET % STATE_LENGTH;
   localparam logic [AW:0]          LENGTH_EXT = (AW + 1)'(STATE_LENGTH);
   localparam logic [AW:0]          MOFF_EXT   = (AW + 1)'(MOFF);
   localparam logic [INDEX_WIDTH:0] LENGTH_IDX = (INDEX_WIDTH + 1)'(STATE_LENGTH);

   logic [AW-1:0] pos_ff;
   logic [AW-1:0] pos_in;
   logic          raw_ff;
   logic          raw_in;
   stage_type     stage_ff;
   stage_type     stage_in;

   logic [AW:0]   pos_plus;
   logic [AW:0]   far_sum;
   logic [AW-1:0] next_pos;
   logic [AW-1:0] far_pos;
   logic          is_draw;
   logic          wrap;

   assign is_draw  = (operation == OP_DRAW);
   assign pos_plus = {1'b0, pos_ff} + (AW + 1)'(1);
   assign wrap     = (pos_plus == LENGTH_EXT);
   assign next_pos = wrap ? '0 : pos_plus[AW-1:0];
   assign far_sum  = {1'b0, pos_ff} + MOFF_EXT;

   always_comb begin
      if (far_sum >= LENGTH_EXT) begin
         far_pos = AW'(far_sum - LENGTH_EXT);
      end else begin
         far_pos = far_sum[AW-1:0];
      end
   end

   always_comb begin
      rd.a = raw_ff ? INDEX_WIDTH'(pos_ff) : INDEX_WIDTH'(next_pos);
      rd.b = INDEX_WIDTH'(far_pos);
      rd.h = INDEX_WIDTH'(pos_ff);
   end

   always_comb begin
      stage_in.valid      = accept;
      stage_in.draw       = is_draw;
      stage_in.raw        = raw_ff;
      stage_in.load_en    = !is_draw && ({1'b0, word_index} < LENGTH_IDX);
      stage_in.waddr      = is_draw ? INDEX_WIDTH'(pos_ff) : word_index;
      stage_in.load_value = word_value;
   end

   always_comb begin
      pos_in = pos_ff;
      raw_in = raw_ff;
      if (accept) begin
         if (is_draw) begin
            pos_in = next_pos;
            if (wrap) begin
               raw_in = 1'b0;
            end
         end else begin
            pos_in = '0;
            raw_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         raw_ff   <= 1'b1;
         stage_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         raw_ff   <= raw_in;
         stage_ff <= stage_in;
      end
   end

   assign stage = stage_ff;

endmodule

/* rtl/mtwg_mixer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mersenne twister mixer
// Rebuilds a state word from the read data, forms the memory write of the
// stage and the word handed to the output queue.
// ----------------------------------------------------------------------------
module mtwg_mixer
   import mtwg_pkg::*;
(
   input  stage_type             stage,
   input  logic [WORD_WIDTH-1:0] rd_a_word,
   input  logic [WORD_WIDTH-1:0] rd_b_word,
   input  logic                  rd_h_bit,
   output write_type             wr,
   output logic                  push,
   output logic [WORD_WIDTH-1:0] push_word
);

   logic [WORD_WIDTH-1:0] joined;
   logic [WORD_WIDTH-1:0] mixed;

   assign joined = ({rd_h_bit, {(WORD_WIDTH - 1){1'b0}}} & HIGH_BIT) | (rd_a_word & LOW_BITS);
   assign mixed  = rd_b_word ^ (joined >> 1) ^ (joined[0] ? FEEDBACK : '0);

   always_comb begin
      wr.en   = stage.valid && (stage.draw ? !stage.raw : stage.load_en);
      wr.addr = stage.waddr;
      wr.data = stage.draw ? mixed : stage.load_value;
   end

   assign push      = stage.valid && stage.draw;
   assign push_word = stage.raw ? rd_a_word : mixed;

endmodule

/* rtl/mtwg_out_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mersenne twister output queue
// Small queue of finished words that parts the pipeline from the receiver.
// ----------------------------------------------------------------------------
module mtwg_out_fifo
   import mtwg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic [WORD_WIDTH-1:0]  push_word,
   input  logic                   pop,
   output logic                   out_valid,
   output logic [WORD_WIDTH-1:0]  out_word,
   output logic [LEVEL_WIDTH-1:0] level
);

   localparam logic [PTR_WIDTH-1:0] LAST_PTR = PTR_WIDTH'(OUT_DEPTH - 1);

   logic [WORD_WIDTH-1:0]  entry_ff [OUT_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff;
   logic [PTR_WIDTH-1:0]   wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff;
   logic [PTR_WIDTH-1:0]   rd_ptr_in;
   logic [LEVEL_WIDTH-1:0] level_ff;
   logic [LEVEL_WIDTH-1:0] level_in;
   logic                   do_pop;

   assign do_pop = pop && (level_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_WIDTH'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_WIDTH'(1);
      end
      if (push && !do_pop) begin
         level_in = level_ff + LEVEL_WIDTH'(1);
      end else if (!push && do_pop) begin
         level_in = level_ff - LEVEL_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   assign out_valid = (level_ff != '0);
   assign out_word  = entry_ff[rd_ptr_ff];
   assign level     = level_ff;

endmodule

/* rtl/mersenne_twister_word_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mersenne twister word generator
// Untempered MT19937-style generator over a memory of state words.
// ----------------------------------------------------------------------------
// The request channel carries load items (operation 0), which write one state
// word if the index lies within the memory and restart the read position at
// zero in a raw pass, and draw items (operation 1), which return one word on
// the response channel. During a raw pass each draw returns the stored word
// unchanged; afterwards each draw rebuilds the word at the read position in
// place and returns it. All state words must be loaded before the first draw.
// Throughput is one item per cycle while the request channel is ready: each
// draw takes two word reads, one top bit read and at most one write in the
// state memories, which have ports for all of them at once. A transferred
// draw is registered with its state reads in the pipeline stage, then written
// into the output queue before its word shows on the response channel.
// Reset clears the read position, sets the raw pass and empties the pipeline;
// the state words keep whatever they held. When the receiver stalls, finished
// words collect in a three-entry queue and the request channel stops taking
// items once the queued words and a draw in the pipeline stage fill it.
// ----------------------------------------------------------------------------
module mersenne_twister_word_generator
   import mtwg_pkg::*;
#(
   parameter int STATE_LENGTH = 624,
   parameter int MIX_OFFSET   = 397
) (
   input  logic      clock,
   input  logic      reset,
   mtwg_req_if.sink   req_link,
   mtwg_rsp_if.source rsp_link
);

   localparam logic [LEVEL_WIDTH:0] DEPTH_EXT = (LEVEL_WIDTH + 1)'(OUT_DEPTH);

   read_type               rd;
   write_type              wr;
   stage_type              stage;
   logic [WORD_WIDTH-1:0]  rd_a_word;
   logic [WORD_WIDTH-1:0]  rd_b_word;
   logic                   rd_h_bit;
   logic                   push;
   logic [WORD_WIDTH-1:0]  push_word;
   logic [LEVEL_WIDTH-1:0] level;
   logic                   accept;
   logic                   pending;

   assign pending        = stage.valid && stage.draw;
   assign req_link.ready = (({1'b0, level} + (LEVEL_WIDTH + 1)'(pending)) < DEPTH_EXT);
   assign accept         = req_link.valid && req_link.ready;

   mtwg_sequencer #(
      .STATE_LENGTH (STATE_LENGTH),
      .MIX_OFFSET   (MIX_OFFSET)
   ) u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .operation  (req_link.operation),
      .word_index (req_link.word_index),
      .word_value (req_link.word_value),
      .rd         (rd),
      .stage      (stage)
   );

   mtwg_state_store #(
      .STATE_LENGTH (STATE_LENGTH)
   ) u_state_store (
      .clock     (clock),
      .rd        (rd),
      .wr        (wr),
      .rd_a_word (rd_a_word),
      .rd_b_word (rd_b_word),
      .rd_h_bit  (rd_h_bit)
   );

   mtwg_mixer u_mixer (
      .stage     (stage),
      .rd_a_word (rd_a_word),
      .rd_b_word (rd_b_word),
      .rd_h_bit  (rd_h_bit),
      .wr        (wr),
      .push      (push),
      .push_word (push_word)
   );

   mtwg_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (rsp_link.ready),
      .out_valid (rsp_link.valid),
      .out_word  (rsp_link.random_word),
      .level     (level)
   );

endmodule

/* rtl/mtwg_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mersenne twister word generator checker
// Port-level assertions on responses after reset and during stalls, capacity and latency.
// ----------------------------------------------------------------------------
module mtwg_checker
   import mtwg_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  req_operation,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [WORD_WIDTH-1:0] rsp_random_word
);

   localparam logic [2:0] MAX_IN_FLIGHT = 3'(OUT_DEPTH + 1);

   logic [2:0] outstanding_ff;
   logic [2:0] outstanding_in;
   logic       draw_transfer;
   logic       rsp_transfer;

   assign draw_transfer = req_valid && req_ready && (req_operation == OP_DRAW);
   assign rsp_transfer  = rsp_valid && rsp_ready;

   always_comb begin
      outstanding_in = outstanding_ff;
      if (draw_transfer && !rsp_transfer) begin
         outstanding_in = outstanding_ff + 3'(1);
      end else if (!draw_transfer && rsp_transfer) begin
         outstanding_in = outstanding_ff - 3'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   a_no_result_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Response valid in the cycle after reset.");

   a_result_needs_draw: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (outstanding_ff != '0))
      else $error("Response offered without an outstanding draw.");

   a_capacity: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= MAX_IN_FLIGHT)
      else $error("More draws in flight than the pipeline can hold.");

   a_idle_latency: assert property (@(posedge clock) disable iff (reset)
      (draw_transfer && (outstanding_ff == '0)) |-> ##2 rsp_valid)
      else $error("Draw on an idle block not answered after two cycles.");

   a_stall_holds_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_random_word))
      else $error("Stalled response word changed.");

endmodule

bind mersenne_twister_word_generator mtwg_checker u_mtwg_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_link.valid),
   .req_ready       (req_link.ready),
   .req_operation   (req_link.operation),
   .rsp_valid       (rsp_link.valid),
   .rsp_ready       (rsp_link.ready),
   .rsp_random_word (rsp_link.random_word)
);

/* dv/mersenne_twister_word_generator_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mersenne twister word generator testbench
// Fills every state word, then sends load and draw transfers with random
// gaps on both channels. A shadow copy of the generator state predicts each
// drawn word, and every word on the response channel is compared in order.
// Raw passes, rebuilt passes across the wrap of the read position, reloads
// and loads to positions beyond the state memory are all covered.
// ----------------------------------------------------------------------------
module mersenne_twister_word_generator_test;
   import mtwg_pkg::*;

   localparam int STATE_LENGTH = 624;
   localparam int MIX_OFFSET   = 397;
   localparam int IDLE_LIMIT   = 1000;

   typedef struct {
      logic                   operation;
      logic [INDEX_WIDTH-1:0] word_index;
      logic [WORD_WIDTH-1:0]  word_value;
   } request_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mtwg_req_if req_link ();
   mtwg_rsp_if rsp_link ();

   mersenne_twister_word_generator #(
      .STATE_LENGTH (STATE_LENGTH),
      .MIX_OFFSET   (MIX_OFFSET)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_link (req_link),
      .rsp_link (rsp_link)
   );

   always #6 clock = ~clock;

   request_item_type      pending_requests[$];
   logic [WORD_WIDTH-1:0] expected_words[$];

   logic [WORD_WIDTH-1:0] shadow_words [STATE_LENGTH];
   int unsigned           shadow_position = 0;
   bit                    shadow_raw      = 1'b1;

   bit                    req_fired   = 1'b0;
   bit                    rsp_fired   = 1'b0;
   bit                    req_calm    = 1'b0;
   bit                    rsp_calm    = 1'b0;
   int unsigned           req_wait    = 0;
   int unsigned           rsp_wait    = 0;
   int unsigned           idle_cycles = 0;
   int unsigned           mismatch_count = 0;
   request_item_type      next_item;
   logic [WORD_WIDTH-1:0] oldest_word;

   function automatic int unsigned draw_wait(inout bit calm);
      if ($urandom_range(0, 39) == 0)
         calm = !calm;
      return calm ? 0 : $urandom_range(0, 5);
   endfunction

   function automatic void report_mismatch(input string what,
                                           input logic [WORD_WIDTH-1:0] want,
                                           input logic [WORD_WIDTH-1:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s: expected %08h, actual %08h", $realtime, what, want, got);
   endfunction

   // Applies one accepted request to the shadow state and records the word
   // that a draw must return.
   function automatic void step_generator(input request_item_type item);
      int unsigned           next_pos;
      int unsigned           far_pos;
      logic [WORD_WIDTH-1:0] joined;
      logic [WORD_WIDTH-1:0] mixed;
      if (item.operation == OP_LOAD) begin
         if (item.word_index < STATE_LENGTH)
            shadow_words[item.word_index] = item.word_value;
         shadow_position = 0;
         shadow_raw      = 1'b1;
      end else begin
         if (!shadow_raw) begin
            next_pos = (shadow_position + 1) % STATE_LENGTH;
            far_pos  = (shadow_position + MIX_OFFSET) % STATE_LENGTH;
            joined   = (shadow_words[shadow_position] & HIGH_BIT) |
                       (shadow_words[next_pos] & LOW_BITS);
            mixed    = shadow_words[far_pos] ^ (joined >> 1);
            if (joined[0])
               mixed ^= FEEDBACK;
            shadow_words[shadow_position] = mixed;
         end
         expected_words.push_back(shadow_words[shadow_position]);
         shadow_position++;
         if (shadow_position >= STATE_LENGTH) begin
            shadow_position = 0;
            shadow_raw      = 1'b0;
         end
      end
   endfunction

   task automatic queue_load(input int unsigned index, input logic [WORD_WIDTH-1:0] value);
      request_item_type item;
      item.operation  = OP_LOAD;
      item.word_index = INDEX_WIDTH'(index);
      item.word_value = value;
      pending_requests.push_back(item);
   endtask

   // The index and value of a draw are ignored by the block, so they carry
   // random bits.
   task automatic queue_draws(input int unsigned count);
      request_item_type item;
      repeat (count) begin
         item.operation  = OP_DRAW;
         item.word_index = INDEX_WIDTH'($urandom);
         item.word_value = $urandom;
         pending_requests.push_back(item);
      end
   endtask

   // Monitor: responses are checked before the request of the same edge is
   // predicted, since a draw cannot answer at the edge that accepts it.
   always @(posedge clock) begin
      if (reset) begin
         req_fired   = 1'b0;
         rsp_fired   = 1'b0;
         idle_cycles = 0;
      end else begin
         req_fired = req_link.valid && req_link.ready;
         rsp_fired = rsp_link.valid && rsp_link.ready;
         if (rsp_fired) begin
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected word", '0, rsp_link.random_word);
            end else begin
               oldest_word = expected_words.pop_front();
               if (rsp_link.random_word !== oldest_word)
                  report_mismatch("random_word", oldest_word, rsp_link.random_word);
            end
         end
         if (req_fired) begin
            next_item.operation  = req_link.operation;
            next_item.word_index = req_link.word_index;
            next_item.word_value = req_link.word_value;
            step_generator(next_item);
         end
         if (req_fired || rsp_fired)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
   end

   // Driver: requests and the response ready change on the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         req_link.valid <= 1'b0;
         rsp_link.ready <= 1'b0;
      end else begin
         if (!req_link.valid || req_fired) begin
            if (req_wait != 0) begin
               req_link.valid <= 1'b0;
               req_wait--;
            end else if (pending_requests.size() != 0) begin
               next_item = pending_requests.pop_front();
               req_link.valid      <= 1'b1;
               req_link.operation  <= next_item.operation;
               req_link.word_index <= next_item.word_index;
               req_link.word_value <= next_item.word_value;
               req_wait = draw_wait(req_calm);
            end else begin
               req_link.valid <= 1'b0;
            end
         end
         if (rsp_fired)
            rsp_wait = draw_wait(rsp_calm);
         if (rsp_wait != 0) begin
            rsp_link.ready <= 1'b0;
            rsp_wait--;
         end else begin
            rsp_link.ready <= 1'b1;
         end
      end
   end

   initial begin
      bit                    stalled;
      int unsigned           index;
      logic [WORD_WIDTH-1:0] value;

      stalled             = 1'b0;
      req_link.valid      = 1'b0;
      req_link.operation  = OP_LOAD;
      req_link.word_index = '0;
      req_link.word_value = '0;
      rsp_link.ready      = 1'b0;

      // Every state word is loaded before the first draw, with the extreme
      // values at the start of the memory.
      for (int i = 0; i < STATE_LENGTH; i++) begin
         case (i)
            0: value = 32'h0000_0000;
            1: value = 32'hFFFF_FFFF;
            2: value = HIGH_BIT;
            3: value = LOW_BITS;
            default: value = $urandom;
         endcase
         queue_load(i, value);
      end
      // Loads beyond the memory write nothing but still restart the pass.
      queue_load(1023, $urandom);
      queue_load(STATE_LENGTH, $urandom);
      queue_draws(4);
      queue_load(2, 32'h0000_0001);
      queue_draws(3);
      queue_load(STATE_LENGTH - 1, 32'hFFFF_FFFF);
      queue_draws(1);

      // The rest of the raw pass is followed by a full rebuilt pass and part
      // of another, so the read position wraps twice.
      queue_draws(2 * STATE_LENGTH + 50);

      // Mostly short runs of draws between reloads of single words.
      for (int i = 0; i < 500; i++) begin
         if ($urandom_range(0, 11) == 0) begin
            if ($urandom_range(0, 7) == 0)
               index = $urandom_range(STATE_LENGTH, 1023);
            else
               index = $urandom_range(0, STATE_LENGTH - 1);
            case ($urandom_range(0, 5))
               0: value = 32'h0000_0000;
               1: value = 32'hFFFF_FFFF;
               default: value = $urandom;
            endcase
            queue_load(index, value);
         end else begin
            queue_draws(1);
         end
      end

      // A reload followed by a run long enough to rebuild from the new state.
      queue_load($urandom_range(0, STATE_LENGTH - 1), $urandom);
      queue_draws(STATE_LENGTH + 80);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_link.valid ||
             expected_words.size() != 0) begin
         @(negedge clock);
         if (idle_cycles >= IDLE_LIMIT) begin
            stalled = 1'b1;
            break;
         end
      end

      if (stalled) begin
         $display("end of test: mismatches");
      end else begin
         repeat (8) @(posedge clock);
         @(negedge clock);
         if (mismatch_count == 0 && expected_words.size() == 0)
            $display("end of test: clean");
         else
            $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

/* mersenne_twister_word_generator.f */
rtl/mtwg_pkg.sv
rtl/mtwg_channels.sv
rtl/mtwg_state_store.sv
rtl/mtwg_sequencer.sv
rtl/mtwg_mixer.sv
rtl/mtwg_out_fifo.sv
rtl/mersenne_twister_word_generator.sv
rtl/mtwg_checker.sv
dv/mersenne_twister_word_generator_test.sv
